### sv/hop_pkg.sv
package hop_pkg;

    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_RUN_ID_HIGH = 2'd0,
        REG_RUN_ID_LOW  = 2'd1,
        REG_FRAME_COUNT = 2'd2
    } hop_reg_idx_t;

    typedef struct packed {
        logic [63:0] run_id_high;
        logic [63:0] run_id_low;
        logic [7:0]  frame_count;
    } hop_cfg_t;

    localparam logic [23:0] COLOR_BACK  = 24'h102030;
    localparam logic [23:0] COLOR_TEXT  = 24'hffffff;
    localparam logic [23:0] COLOR_BLOCK = 24'h00ff80;

    // Text geometry: digits are 36x60 on a pitch of 60 pixels.
    localparam logic [10:0] TEXT_X0       = 11'd60;
    localparam logic [10:0] TEXT_SPAN     = 11'd960;
    localparam logic [5:0]  CELL_W        = 6'd36;
    localparam logic [5:0]  FONT_SCALE    = 6'd12;
    localparam logic [9:0]  TEXT_PITCH    = 10'd60;
    // Reciprocal of the pitch in 16-bit fixed point, exact below TEXT_SPAN.
    localparam logic [19:0] PITCH_RECIP   = 20'd1093;
    localparam logic [11:0] ROW0_Y0       = 12'd240;
    localparam logic [11:0] ROW1_Y0       = 12'd336;
    localparam logic [11:0] COUNTER_Y0    = 12'd500;
    localparam logic [11:0] CELL_H        = 12'd60;

    localparam logic [11:0] BLOCK_Y0   = 12'd700;
    localparam logic [11:0] BLOCK_Y1   = 12'd850;
    localparam logic [15:0] BLOCK_X0   = 16'd60;
    localparam logic [15:0] BLOCK_X1   = 16'd120;
    localparam logic [14:0] BLOCK_STEP = 15'd80;

    function automatic logic [14:0] glyph_bits(input logic [3:0] nib);
        logic [15:0] g;
        case (nib)
            4'h0: g = 16'h7b6f;
            4'h1: g = 16'h2492;
            4'h2: g = 16'h73e7;
            4'h3: g = 16'h73cf;
            4'h4: g = 16'h5bc9;
            4'h5: g = 16'h79cf;
            4'h6: g = 16'h79ef;
            4'h7: g = 16'h7249;
            4'h8: g = 16'h7bef;
            4'h9: g = 16'h7bcf;
            4'ha: g = 16'h7bed;
            4'hb: g = 16'h6bae;
            4'hc: g = 16'h7927;
            4'hd: g = 16'h6b6e;
            4'he: g = 16'h79e7;
            default: g = 16'h79e4;
        endcase
        return g[14:0];
    endfunction

endpackage

### sv/hop_coord_if.sv
interface hop_coord_if;
    logic        valid;
    logic        ready;
    logic [10:0] pixel_x;
    logic [11:0] pixel_y;

    modport source (output valid, output pixel_x, output pixel_y, input ready);
    modport sink (input valid, input pixel_x, input pixel_y, output ready);
endinterface

### sv/hop_color_if.sv
interface hop_color_if;
    logic        valid;
    logic        ready;
    logic [23:0] pixel_color;

    modport source (output valid, output pixel_color, input ready);
    modport sink (input valid, input pixel_color, output ready);
endinterface

### sv/hex_overlay_pattern_generator.sv
// Each accepted coordinate is registered in the first stage, and its colour is
// registered in the second stage and offered from there.
// Throughput: one pixel per cycle while the colour output is not stalled, set by the
// coordinate register feeding the colour register through a single pass of shading logic.
// Reset: asynchronous and active low; it empties both stages and clears the
// run identifier and the frame count to zero.
module hex_overlay_pattern_generator #(
    parameter int IMAGE_WIDTH  = 1080,
    parameter int IMAGE_HEIGHT = 2340
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hop_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hop_pkg::CFG_DATA_W-1:0]  cfg_data,
    hop_coord_if.sink                       coord,
    hop_color_if.source                     color
);
    import hop_pkg::*;

    hop_cfg_t    cfg;
    logic        s1_valid_reg;
    logic [10:0] x_reg;
    logic [11:0] y_reg;
    logic        out_valid_reg;
    logic [23:0] color_reg;
    logic [23:0] color_next;
    logic        advance;
    logic        take;

    hop_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    hop_pixel_shade #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) u_shade (
        .pixel_x     (x_reg),
        .pixel_y     (y_reg),
        .cfg         (cfg),
        .pixel_color (color_next)
    );

    // The colour register moves whenever it is empty or its transfer completes.
    assign advance     = !out_valid_reg || color.ready;
    assign coord.ready = !s1_valid_reg || advance;
    assign take        = coord.valid && coord.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (coord.ready)
                s1_valid_reg <= coord.valid;
            if (advance)
                out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            x_reg <= coord.pixel_x;
            y_reg <= coord.pixel_y;
        end
        if (advance && s1_valid_reg)
            color_reg <= color_next;
    end

    assign color.valid       = out_valid_reg;
    assign color.pixel_color = color_reg;

    a_take_lands: assert property (@(posedge clk) disable iff (!rst_n)
        take |=> s1_valid_reg)
        else $error("accepted coordinate did not reach the first stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && out_valid_reg && !color.ready) |=> (s1_valid_reg && $stable(x_reg)
            && $stable(y_reg)))
        else $error("pending coordinate lost during an output stall");

    a_no_repeat: assert property (@(posedge clk) disable iff (!rst_n)
        (color.valid && color.ready && !s1_valid_reg) |=> !color.valid)
        else $error("colour offered again without a new coordinate");

endmodule

### sv/hop_cfg_regs.sv
module hop_cfg_regs (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [hop_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hop_pkg::CFG_DATA_W-1:0]  cfg_data,
    output hop_pkg::hop_cfg_t              cfg
);
    import hop_pkg::*;

    hop_cfg_t cfg_reg;
    hop_cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (hop_reg_idx_t'(cfg_index))
                REG_RUN_ID_HIGH: cfg_next.run_id_high = cfg_data;
                REG_RUN_ID_LOW:  cfg_next.run_id_low  = cfg_data;
                REG_FRAME_COUNT: cfg_next.frame_count = cfg_data[7:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

### sv/hop_pixel_shade.sv
module hop_pixel_shade #(
    parameter int IMAGE_WIDTH  = 1080,
    parameter int IMAGE_HEIGHT = 2340
) (
    input  logic [10:0]       pixel_x,
    input  logic [11:0]       pixel_y,
    input  hop_pkg::hop_cfg_t cfg,
    output logic [23:0]       pixel_color
);
    import hop_pkg::*;

    localparam logic [12:0] WIDTH_LIM  = 13'(IMAGE_WIDTH);
    localparam logic [12:0] HEIGHT_LIM = 13'(IMAGE_HEIGHT);

    logic        in_image;
    logic [10:0] x_off;
    logic        span_ok;
    logic [19:0] prod;
    logic [3:0]  k;
    logic [9:0]  dx_full;
    logic [5:0]  dx;
    logic [1:0]  col;
    logic        row0;
    logic        row1;
    logic        ctr;
    logic [11:0] dy_full;
    logic [5:0]  dy;
    logic [2:0]  row;
    logic [3:0]  nib;
    logic [3:0]  bit_idx;
    logic [14:0] glyph;
    logic        text_lit;
    logic [14:0] block_off;
    logic [15:0] x_wide;
    logic        block_hit;

    assign in_image = ({2'b00, pixel_x} < WIDTH_LIM) && ({1'b0, pixel_y} < HEIGHT_LIM);

    // Digit column by reciprocal multiplication; the remainder gives the offset in the cell.
    assign x_off   = pixel_x - TEXT_X0;
    assign span_ok = (pixel_x >= TEXT_X0) && (x_off < TEXT_SPAN);
    assign prod    = 20'(x_off[9:0]) * PITCH_RECIP;
    assign k       = prod[19:16];
    assign dx_full = x_off[9:0] - 10'(10'(k) * TEXT_PITCH);
    assign dx      = dx_full[5:0];

    always_comb
    begin
        if (dx >= 6'(2 * FONT_SCALE))
            col = 2'd2;
        else if (dx >= FONT_SCALE)
            col = 2'd1;
        else
            col = 2'd0;
    end

    assign row0 = (pixel_y >= ROW0_Y0) && (pixel_y < ROW0_Y0 + CELL_H);
    assign row1 = (pixel_y >= ROW1_Y0) && (pixel_y < ROW1_Y0 + CELL_H);
    assign ctr  = (pixel_y >= COUNTER_Y0) && (pixel_y < COUNTER_Y0 + CELL_H) && (k < 4'd2);

    always_comb
    begin
        if (row0)
            dy_full = pixel_y - ROW0_Y0;
        else if (row1)
            dy_full = pixel_y - ROW1_Y0;
        else
            dy_full = pixel_y - COUNTER_Y0;
    end
    assign dy = dy_full[5:0];

    always_comb
    begin
        if (dy >= 6'(4 * FONT_SCALE))
            row = 3'd4;
        else if (dy >= 6'(3 * FONT_SCALE))
            row = 3'd3;
        else if (dy >= 6'(2 * FONT_SCALE))
            row = 3'd2;
        else if (dy >= FONT_SCALE)
            row = 3'd1;
        else
            row = 3'd0;
    end

    // The first character of each word sits in its top nibble.
    always_comb
    begin
        if (row0)
            nib = cfg.run_id_high[{~k, 2'b00} +: 4];
        else if (row1)
            nib = cfg.run_id_low[{~k, 2'b00} +: 4];
        else if (k[0])
            nib = cfg.frame_count[3:0];
        else
            nib = cfg.frame_count[7:4];
    end

    assign glyph    = glyph_bits(nib);
    assign bit_idx  = 4'd14 - 4'(4'(row) * 4'd3) - 4'(col);
    assign text_lit = span_ok && (dx < CELL_W) && (row0 || row1 || ctr) && glyph[bit_idx];

    assign block_off = 15'(cfg.frame_count) * BLOCK_STEP;
    assign x_wide    = 16'(pixel_x);
    assign block_hit = (pixel_y >= BLOCK_Y0) && (pixel_y < BLOCK_Y1)
                    && (x_wide >= 16'(block_off) + BLOCK_X0)
                    && (x_wide < 16'(block_off) + BLOCK_X1);

    always_comb
    begin
        if (!in_image)
            pixel_color = COLOR_BACK;
        else if (block_hit)
            pixel_color = COLOR_BLOCK;
        else if (text_lit)
            pixel_color = COLOR_TEXT;
        else
            pixel_color = COLOR_BACK;
    end

endmodule

### tb/hop_color_checker.sv
`timescale 1ns / 100ps

module hop_color_checker #(
    parameter int IMAGE_WIDTH  = 1080,
    parameter int IMAGE_HEIGHT = 2340
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [hop_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [hop_pkg::CFG_DATA_W-1:0]  cfg_data,
    hop_coord_if                            coord,
    hop_color_if                            color,
    output int                              mismatches,
    output int                              pending,
    output int                              pixels_checked
);
    import hop_pkg::*;

    localparam int GLYPH_X0    = 60;
    localparam int GLYPH_PITCH = 60;
    localparam int GLYPH_W     = 36;
    localparam int GLYPH_H     = 60;
    localparam int GLYPH_SCALE = 12;
    localparam int ID_ROW0_Y   = 240;
    localparam int ID_ROW1_Y   = 336;
    localparam int FRAME_ROW_Y = 500;
    localparam int BAR_Y0      = 700;
    localparam int BAR_Y1      = 850;
    localparam int BAR_X0      = 60;
    localparam int BAR_W       = 60;
    localparam int BAR_STEP    = 80;

    // 3x5 glyphs, top row in bits 14..12, leftmost column in the highest bit of each row.
    localparam logic [15:0] DIGIT_FONT [16] = '{
        16'h7b6f, 16'h2492, 16'h73e7, 16'h73cf, 16'h5bc9, 16'h79cf, 16'h79ef, 16'h7249,
        16'h7bef, 16'h7bcf, 16'h7bed, 16'h6bae, 16'h7927, 16'h6b6e, 16'h79e7, 16'h79e4
    };

    typedef struct {
        logic [10:0] x;
        logic [11:0] y;
        logic [23:0] rgb;
    } pixel_expect_t;

    pixel_expect_t expected_pixels[$];
    hop_cfg_t      regs;

    function automatic logic [23:0] shade_pixel(input logic [10:0] px, input logic [11:0] py,
                                                input hop_cfg_t cfg);
        int         x;
        int         y;
        int         k;
        int         dx;
        int         dy;
        int         bar_left;
        logic       has_digit;
        logic [3:0] digit;
        logic       lit;
        x = int'(px);
        y = int'(py);
        k = 0;
        dx = 0;
        dy = 0;
        has_digit = 1'b0;
        digit = 4'h0;
        lit = 1'b0;
        if (x >= IMAGE_WIDTH || y >= IMAGE_HEIGHT)
            return COLOR_BACK;
        if (x >= GLYPH_X0)
        begin
            k  = (x - GLYPH_X0) / GLYPH_PITCH;
            dx = (x - GLYPH_X0) % GLYPH_PITCH;
            if (dx < GLYPH_W)
            begin
                if (k < 16 && y >= ID_ROW0_Y && y < ID_ROW0_Y + GLYPH_H)
                begin
                    dy = y - ID_ROW0_Y;
                    digit = cfg.run_id_high[(15 - k) * 4 +: 4];
                    has_digit = 1'b1;
                end
                else if (k < 16 && y >= ID_ROW1_Y && y < ID_ROW1_Y + GLYPH_H)
                begin
                    dy = y - ID_ROW1_Y;
                    digit = cfg.run_id_low[(15 - k) * 4 +: 4];
                    has_digit = 1'b1;
                end
                else if (k < 2 && y >= FRAME_ROW_Y && y < FRAME_ROW_Y + GLYPH_H)
                begin
                    dy = y - FRAME_ROW_Y;
                    digit = (k == 0) ? cfg.frame_count[7:4] : cfg.frame_count[3:0];
                    has_digit = 1'b1;
                end
            end
        end
        if (has_digit)
            lit = DIGIT_FONT[digit][14 - (dy / GLYPH_SCALE) * 3 - dx / GLYPH_SCALE];
        // The bar is drawn last and is clipped by the width test above.
        bar_left = BAR_X0 + BAR_STEP * int'(cfg.frame_count);
        if (y >= BAR_Y0 && y < BAR_Y1 && x >= bar_left && x < bar_left + BAR_W)
            return COLOR_BLOCK;
        return lit ? COLOR_TEXT : COLOR_BACK;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        pixel_expect_t head;
        pixel_expect_t fresh;
        if (!rst_n)
        begin
            regs = '0;
            expected_pixels.delete();
            mismatches = 0;
            pending = 0;
            pixels_checked = 0;
        end
        else
        begin
            if (color.valid && color.ready)
            begin
                if (expected_pixels.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: colour transfer %06h with no pixel outstanding",
                             $time, color.pixel_color);
                end
                else
                begin
                    head = expected_pixels.pop_front();
                    pixels_checked++;
                    if (color.pixel_color !== head.rgb)
                    begin
                        mismatches++;
                        $display("%0t: pixel (%0d,%0d) expected %06h, got %06h",
                                 $time, head.x, head.y, head.rgb, color.pixel_color);
                    end
                end
            end
            if (coord.valid && coord.ready)
            begin
                fresh.x = coord.pixel_x;
                fresh.y = coord.pixel_y;
                fresh.rgb = shade_pixel(coord.pixel_x, coord.pixel_y, regs);
                expected_pixels.push_back(fresh);
            end
            // Registers only change while idle, so a write never affects a pixel in flight.
            if (cfg_we)
            begin
                case (hop_reg_idx_t'(cfg_index))
                    REG_RUN_ID_HIGH: regs.run_id_high = cfg_data;
                    REG_RUN_ID_LOW:  regs.run_id_low = cfg_data;
                    REG_FRAME_COUNT: regs.frame_count = cfg_data[7:0];
                    default: ;
                endcase
            end
            pending = expected_pixels.size();
        end
    end

endmodule

### tb/tb.sv
`timescale 1ns / 100ps

module tb;
    import hop_pkg::*;

    localparam int IMAGE_WIDTH    = 1080;
    localparam int IMAGE_HEIGHT   = 2340;
    localparam int PHASES         = 11;
    localparam int RESET_ITEMS    = 60;
    localparam int PHASE_ITEMS    = 150;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 4000;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we;
    hop_reg_idx_t           cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    hop_coord_if coord_ch ();
    hop_color_if color_ch ();

    int         mismatches;
    int         pending;
    int         pixels_checked;
    int         pixels_sent = 0;
    int         settings_used = 0;
    int         quiet_cycles = 0;
    logic [7:0] cur_fc = 8'h00;
    logic       idling_on = 1'b1;
    logic       hold_armed = 1'b0;
    logic       hold_done = 1'b0;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    hex_overlay_pattern_generator #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .coord     (coord_ch),
        .color     (color_ch)
    );

    hop_color_checker #(
        .IMAGE_WIDTH  (IMAGE_WIDTH),
        .IMAGE_HEIGHT (IMAGE_HEIGHT)
    ) i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .coord          (coord_ch),
        .color          (color_ch),
        .mismatches     (mismatches),
        .pending        (pending),
        .pixels_checked (pixels_checked)
    );

    // Any transfer or register write counts as progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((coord_ch.valid && coord_ch.ready) || (color_ch.valid && color_ch.ready) || cfg_we)
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, quiet_cycles);
                $display("tb failed");
                $finish;
            end
        end
    end

    // Colour sink: random back-pressure, plus one long hold-off when armed.
    initial
    begin : colour_sink
        color_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_done)
            begin
                color_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_done = 1'b1;
            end
            color_ch.ready <= !(idling_on && $urandom_range(99) < 28);
        end
    end

    task automatic write_register(input hop_reg_idx_t idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic load_settings(input logic [63:0] id_high, input logic [63:0] id_low,
                                 input logic [7:0] fc);
        write_register(REG_RUN_ID_HIGH, id_high);
        write_register(REG_RUN_ID_LOW, id_low);
        write_register(REG_FRAME_COUNT, {56'd0, fc});
        cur_fc = fc;
        settings_used++;
    endtask

    task automatic send_pixel(input logic [10:0] x, input logic [11:0] y);
        while (idling_on && $urandom_range(99) < 28)
        begin
            coord_ch.valid <= 1'b0;
            @(posedge clk);
        end
        coord_ch.valid <= 1'b1;
        coord_ch.pixel_x <= x;
        coord_ch.pixel_y <= y;
        do
            @(posedge clk);
        while (!coord_ch.ready);
        pixels_sent++;
    endtask

    // Biased towards the digit rows, the frame digits and the bar, with some
    // coordinates drawn from the whole field range to reach beyond the image.
    task automatic send_random_pixel();
        int          zone;
        int          bar_left;
        int          lo;
        logic [10:0] x;
        logic [11:0] y;
        zone = $urandom_range(99);
        bar_left = 60 + 80 * int'(cur_fc);
        if (zone < 25)
        begin
            x = 11'($urandom_range(0, IMAGE_WIDTH - 1));
            y = 12'($urandom_range(230, 405));
        end
        else if (zone < 40)
        begin
            x = 11'($urandom_range(0, 200));
            y = 12'($urandom_range(490, 570));
        end
        else if (zone < 60)
        begin
            if (bar_left > IMAGE_WIDTH)
                lo = IMAGE_WIDTH - 180;
            else
                lo = (bar_left >= 40) ? bar_left - 40 : 0;
            x = 11'($urandom_range(lo, lo + 180));
            y = 12'($urandom_range(690, 860));
        end
        else if (zone < 85)
        begin
            x = 11'($urandom_range(0, IMAGE_WIDTH - 1));
            y = 12'($urandom_range(0, IMAGE_HEIGHT - 1));
        end
        else
        begin
            x = 11'($urandom_range(0, 2047));
            y = 12'($urandom_range(0, 4095));
        end
        send_pixel(x, y);
    endtask

    task automatic drain_pipeline();
        coord_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (pending != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // With frame count 11 the bar spans columns 940 to 999.
    task automatic send_directed();
        send_pixel(11'd0, 12'd0);
        send_pixel(11'd1079, 12'd2339);
        send_pixel(11'd1080, 12'd0);
        send_pixel(11'd0, 12'd2340);
        send_pixel(11'd2047, 12'd4095);
        send_pixel(11'd1080, 12'd2340);
        send_pixel(11'd60, 12'd240);
        send_pixel(11'd95, 12'd299);
        send_pixel(11'd96, 12'd240);
        send_pixel(11'd995, 12'd240);
        send_pixel(11'd1020, 12'd240);
        send_pixel(11'd60, 12'd336);
        send_pixel(11'd995, 12'd395);
        send_pixel(11'd60, 12'd396);
        send_pixel(11'd60, 12'd500);
        send_pixel(11'd155, 12'd559);
        send_pixel(11'd180, 12'd500);
        send_pixel(11'd940, 12'd700);
        send_pixel(11'd999, 12'd849);
        send_pixel(11'd939, 12'd700);
        send_pixel(11'd1000, 12'd700);
        send_pixel(11'd940, 12'd850);
        send_pixel(11'd940, 12'd699);
    endtask

    initial
    begin : stimulus
        int          p;
        logic [63:0] id_high;
        logic [63:0] id_low;
        logic [7:0]  fc;
        coord_ch.valid <= 1'b0;
        coord_ch.pixel_x <= '0;
        coord_ch.pixel_y <= '0;
        cfg_we <= 1'b0;
        cfg_index <= REG_RUN_ID_HIGH;
        cfg_data <= '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        // First pass runs on the register values left by reset.
        settings_used++;
        repeat (RESET_ITEMS) send_random_pixel();
        drain_pipeline();

        for (p = 1; p <= PHASES; p++)
        begin
            id_high = {$urandom, $urandom};
            id_low = {$urandom, $urandom};
            fc = 8'($urandom_range(0, 255));
            case (p)
                1:
                begin
                    id_high = 64'h0123456789abcdef;
                    id_low = 64'hfedcba9876543210;
                    fc = 8'd11;
                end
                2:
                begin
                    id_high = '1;
                    id_low = '1;
                    fc = 8'hff;
                end
                3:
                begin
                    id_high = '0;
                    id_low = '0;
                    fc = 8'h00;
                end
                4: fc = 8'd12;  // bar ends exactly at the right edge
                5: fc = 8'd13;  // bar entirely past the right edge
                6: fc = 8'd1;
                8: fc = 8'($urandom_range(0, 13));
                default: ;
            endcase
            load_settings(id_high, id_low, fc);
            idling_on = !(p == 6 || p == 7);
            if (p == 1)
                send_directed();
            if (p == 4)
                hold_armed = 1'b1;
            repeat (PHASE_ITEMS) send_random_pixel();
            drain_pipeline();
        end

        $display("Checked %0d of %0d pixels over %0d register settings.",
                 pixels_checked, pixels_sent, settings_used);
        $display("Covered off-image coordinates, clipped bar positions and a %0d-cycle stall.",
                 HOLD_CYCLES);
        if (mismatches == 0 && pending == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
